// ===== rtl/cts_pkg.sv =====
package cts_pkg;

    localparam int unsigned COORD_W  = 16;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned RETRY_W  = 8;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [2:0] EV_START_WRITE = 3'd0;
    localparam logic [2:0] EV_START_READ  = 3'd1;
    localparam logic [2:0] EV_READY       = 3'd2;
    localparam logic [2:0] EV_XFER_DONE   = 3'd3;
    localparam logic [2:0] EV_TICK        = 3'd4;
    localparam logic [2:0] EV_COLLECT     = 3'd5;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_SENDING    = 3'd1;
    localparam logic [2:0] PH_WAIT_READY = 3'd2;
    localparam logic [2:0] PH_READING    = 3'd3;
    localparam logic [2:0] PH_DONE       = 3'd4;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [2:0] RES_NO_JOB    = 3'd0;
    localparam logic [2:0] RES_PENDING   = 3'd1;
    localparam logic [2:0] RES_OK        = 3'd2;
    localparam logic [2:0] RES_BUS_ERROR = 3'd3;
    localparam logic [2:0] RES_TIMEOUT   = 3'd4;
    localparam logic [2:0] RES_NACK_FAIL = 3'd5;

    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_WRITE    = 3'd1;
    localparam logic [2:0] ACT_READ     = 3'd2;
    localparam logic [2:0] ACT_READBACK = 3'd3;
    localparam logic [2:0] ACT_ABORT    = 3'd4;

    localparam logic [1:0] SS_ACCEPTED  = 2'd0;
    localparam logic [1:0] SS_ERROR     = 2'd1;
    localparam logic [1:0] SS_BUSY      = 2'd2;
    localparam logic [1:0] SS_NOT_START = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_READY_TIMEOUT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE         = 2'd3;

    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST      = 8'd3;
    localparam logic [TICK_W-1:0]  TRANSFER_TIMEOUT_RST = 16'd100;
    localparam logic [TICK_W-1:0]  READY_TIMEOUT_RST    = 16'd100;
    localparam logic [BYTE_W-1:0]  ACK_CODE_RST         = 8'd6;

    typedef struct packed {
        logic [RETRY_W-1:0] max_retries;
        logic [TICK_W-1:0]  transfer_timeout;
        logic [TICK_W-1:0]  ready_timeout;
        logic [BYTE_W-1:0]  ack_code;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         phase;
        logic [1:0]         job_kind;
        logic [RETRY_W-1:0] retries_remaining;
        logic [TICK_W-1:0]  elapsed_ticks;
        logic               ready_latched;
        logic [2:0]         final_result;
        logic [COORD_W-1:0] job_x;
        logic [COORD_W-1:0] job_y;
        logic [LEN_W-1:0]   job_length;
    } state_t;

    typedef struct packed {
        logic [2:0]         event_req;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [LEN_W-1:0]   length;
        logic               bus_error;
        logic [BYTE_W-1:0]  ack_value;
        logic               issue_refused;
    } event_t;

    typedef struct packed {
        logic [1:0]         start_status;
        logic [2:0]         action;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [LEN_W-1:0]   out_length;
        logic [2:0]         job_status;
    } result_t;

endpackage

// ===== rtl/cts_if.sv =====
interface cts_in_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   event_req;
    logic [cts_pkg::COORD_W-1:0]  coord_x;
    logic [cts_pkg::COORD_W-1:0]  coord_y;
    logic [cts_pkg::LEN_W-1:0]    length;
    logic                         bus_error;
    logic [cts_pkg::BYTE_W-1:0]   ack_value;
    logic                         issue_refused;

    modport source
    (
        output valid, event_req, coord_x, coord_y, length, bus_error, ack_value,
               issue_refused,
        input  ready
    );
    modport sink
    (
        input  valid, event_req, coord_x, coord_y, length, bus_error, ack_value,
               issue_refused,
        output ready
    );
endinterface

interface cts_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   start_status;
    logic [2:0]                   action;
    logic [cts_pkg::COORD_W-1:0]  out_x;
    logic [cts_pkg::COORD_W-1:0]  out_y;
    logic [cts_pkg::LEN_W-1:0]    out_length;
    logic [2:0]                   job_status;

    modport source
    (
        output valid, start_status, action, out_x, out_y, out_length, job_status,
        input  ready
    );
    modport sink
    (
        input  valid, start_status, action, out_x, out_y, out_length, job_status,
        output ready
    );
endinterface

// ===== rtl/cts_cfg.sv =====
module cts_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [cts_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [cts_pkg::CFG_DATA_W-1:0]      wr_data,
    output cts_pkg::cfg_t                       cfg
);

    cts_pkg::cfg_t cfg_reg;
    cts_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                cts_pkg::REG_MAX_RETRIES:
                    cfg_next.max_retries = wr_data[cts_pkg::RETRY_W-1:0];
                cts_pkg::REG_TRANSFER_TIMEOUT:
                    cfg_next.transfer_timeout = wr_data[cts_pkg::TICK_W-1:0];
                cts_pkg::REG_READY_TIMEOUT:
                    cfg_next.ready_timeout = wr_data[cts_pkg::TICK_W-1:0];
                cts_pkg::REG_ACK_CODE:
                    cfg_next.ack_code = wr_data[cts_pkg::BYTE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_retries      <= cts_pkg::MAX_RETRIES_RST;
            cfg_reg.transfer_timeout <= cts_pkg::TRANSFER_TIMEOUT_RST;
            cfg_reg.ready_timeout    <= cts_pkg::READY_TIMEOUT_RST;
            cfg_reg.ack_code         <= cts_pkg::ACK_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/cts_step.sv =====
module cts_step
(
    input  cts_pkg::state_t   cur,
    input  cts_pkg::cfg_t     cfg,
    input  cts_pkg::event_t   ev,
    output cts_pkg::state_t   nxt,
    output cts_pkg::result_t  res
);

    logic [cts_pkg::TICK_W-1:0] ticks_inc;
    logic                       collected;

    // saturating tick count
    assign ticks_inc = (&cur.elapsed_ticks) ? cur.elapsed_ticks
                                            : cur.elapsed_ticks + 1'b1;

    always_comb
    begin
        nxt              = cur;
        res.start_status = cts_pkg::SS_NOT_START;
        res.action       = cts_pkg::ACT_NONE;
        res.out_x        = '0;
        res.out_y        = '0;
        res.out_length   = '0;
        collected        = 1'b0;

        unique case (ev.event_req)
            cts_pkg::EV_START_WRITE, cts_pkg::EV_START_READ:
            begin
                if (ev.length == '0)
                begin
                    res.start_status = cts_pkg::SS_ERROR;
                end
                else if (cur.phase != cts_pkg::PH_IDLE)
                begin
                    res.start_status = cts_pkg::SS_BUSY;
                end
                else
                begin
                    nxt.job_x             = ev.coord_x;
                    nxt.job_y             = ev.coord_y;
                    nxt.job_length        = ev.length;
                    nxt.retries_remaining = cfg.max_retries;
                    nxt.ready_latched     = 1'b0;
                    if (ev.issue_refused)
                    begin
                        nxt.job_kind     = cts_pkg::KIND_NONE;
                        res.start_status = cts_pkg::SS_ERROR;
                    end
                    else
                    begin
                        nxt.job_kind      = (ev.event_req == cts_pkg::EV_START_WRITE)
                                            ? cts_pkg::KIND_WRITE : cts_pkg::KIND_READ;
                        res.action        = (ev.event_req == cts_pkg::EV_START_WRITE)
                                            ? cts_pkg::ACT_WRITE : cts_pkg::ACT_READ;
                        res.out_x         = ev.coord_x;
                        res.out_y         = ev.coord_y;
                        res.out_length    = ev.length;
                        nxt.phase         = cts_pkg::PH_SENDING;
                        nxt.elapsed_ticks = '0;
                        res.start_status  = cts_pkg::SS_ACCEPTED;
                    end
                end
            end
            cts_pkg::EV_READY:
            begin
                if (cur.phase == cts_pkg::PH_WAIT_READY)
                begin
                    nxt.ready_latched = 1'b0;
                    if (ev.issue_refused)
                    begin
                        nxt.final_result = cts_pkg::RES_BUS_ERROR;
                        nxt.phase        = cts_pkg::PH_DONE;
                    end
                    else
                    begin
                        res.action        = cts_pkg::ACT_READBACK;
                        res.out_length    = (cur.job_kind == cts_pkg::KIND_WRITE)
                                            ? cts_pkg::LEN_W'(1) : cur.job_length;
                        nxt.phase         = cts_pkg::PH_READING;
                        nxt.elapsed_ticks = '0;
                    end
                end
                else
                begin
                    nxt.ready_latched = 1'b1;
                end
            end
            cts_pkg::EV_XFER_DONE:
            begin
                priority if (cur.phase == cts_pkg::PH_SENDING)
                begin
                    if (ev.bus_error)
                    begin
                        nxt.final_result = cts_pkg::RES_BUS_ERROR;
                        nxt.phase        = cts_pkg::PH_DONE;
                    end
                    else
                    begin
                        nxt.phase         = cts_pkg::PH_WAIT_READY;
                        nxt.elapsed_ticks = '0;
                        if (cur.ready_latched)
                        begin
                            nxt.ready_latched = 1'b0;
                            if (ev.issue_refused)
                            begin
                                nxt.final_result = cts_pkg::RES_BUS_ERROR;
                                nxt.phase        = cts_pkg::PH_DONE;
                            end
                            else
                            begin
                                res.action     = cts_pkg::ACT_READBACK;
                                res.out_length = (cur.job_kind == cts_pkg::KIND_WRITE)
                                                 ? cts_pkg::LEN_W'(1) : cur.job_length;
                                nxt.phase      = cts_pkg::PH_READING;
                            end
                        end
                    end
                end
                else if (cur.phase == cts_pkg::PH_READING)
                begin
                    if (ev.bus_error)
                    begin
                        nxt.final_result = cts_pkg::RES_BUS_ERROR;
                        nxt.phase        = cts_pkg::PH_DONE;
                    end
                    else if (cur.job_kind != cts_pkg::KIND_WRITE
                             || ev.ack_value == cfg.ack_code)
                    begin
                        nxt.final_result = cts_pkg::RES_OK;
                        nxt.phase        = cts_pkg::PH_DONE;
                    end
                    else if (cur.retries_remaining != '0)
                    begin
                        // resend after a non-acknowledge
                        nxt.retries_remaining = cur.retries_remaining - 1'b1;
                        nxt.ready_latched     = 1'b0;
                        if (ev.issue_refused)
                        begin
                            nxt.final_result = cts_pkg::RES_BUS_ERROR;
                            nxt.phase        = cts_pkg::PH_DONE;
                        end
                        else
                        begin
                            res.action        = cts_pkg::ACT_WRITE;
                            res.out_x         = cur.job_x;
                            res.out_y         = cur.job_y;
                            res.out_length    = cur.job_length;
                            nxt.phase         = cts_pkg::PH_SENDING;
                            nxt.elapsed_ticks = '0;
                        end
                    end
                    else
                    begin
                        nxt.final_result = cts_pkg::RES_NACK_FAIL;
                        nxt.phase        = cts_pkg::PH_DONE;
                    end
                end
                else
                begin
                    nxt = cur;
                end
            end
            cts_pkg::EV_TICK:
            begin
                if (cur.phase == cts_pkg::PH_WAIT_READY)
                begin
                    nxt.elapsed_ticks = ticks_inc;
                    if (ticks_inc > cfg.ready_timeout)
                    begin
                        nxt.final_result = cts_pkg::RES_TIMEOUT;
                        nxt.phase        = cts_pkg::PH_DONE;
                    end
                end
                else if (cur.phase == cts_pkg::PH_SENDING
                         || cur.phase == cts_pkg::PH_READING)
                begin
                    nxt.elapsed_ticks = ticks_inc;
                    if (ticks_inc > cfg.transfer_timeout)
                    begin
                        res.action       = cts_pkg::ACT_ABORT;
                        nxt.final_result = cts_pkg::RES_TIMEOUT;
                        nxt.phase        = cts_pkg::PH_DONE;
                    end
                end
            end
            cts_pkg::EV_COLLECT:
            begin
                collected = 1'b1;
            end
            default:
            begin
                nxt = cur;
            end
        endcase

        if (nxt.phase == cts_pkg::PH_DONE)
        begin
            res.job_status = nxt.final_result;
        end
        else if (nxt.phase == cts_pkg::PH_IDLE)
        begin
            res.job_status = cts_pkg::RES_NO_JOB;
        end
        else
        begin
            res.job_status = cts_pkg::RES_PENDING;
        end

        if (collected && nxt.phase == cts_pkg::PH_DONE)
        begin
            nxt.phase    = cts_pkg::PH_IDLE;
            nxt.job_kind = cts_pkg::KIND_NONE;
        end
    end

endmodule

// ===== rtl/command_transaction_sequencer.sv =====
// channel  dir  handshake     word
// evt      in   valid/ready   event_req, coord_x, coord_y, length, bus_error,
//                             ack_value, issue_refused
// res      out  valid/ready   start_status, action, out_x, out_y, out_length,
//                             job_status
// cfg      in   wr_en         wr_index, wr_data (write only)
//
// one word per cycle while the result is not stalled; a result appears in the cycle after its event is taken
// the job state and the result register are updated at the same edge
// evt.ready is high while the result register is empty or being emptied
// a stalled result holds the input back; nothing is dropped
// reset: idle, no job, config registers at their default values
module command_transaction_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    cts_in_if.sink                            evt,
    cts_out_if.source                         res,
    input  logic                              wr_en,
    input  logic [cts_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [cts_pkg::CFG_DATA_W-1:0]    wr_data
);

    cts_pkg::cfg_t     cfg;
    cts_pkg::event_t   ev;
    cts_pkg::state_t   state_reg;
    cts_pkg::state_t   state_next;
    cts_pkg::result_t  step_res;
    cts_pkg::result_t  res_reg;
    logic              res_valid_reg;
    logic              res_valid_next;
    logic              accept;

    cts_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    assign ev.event_req     = evt.event_req;
    assign ev.coord_x       = evt.coord_x;
    assign ev.coord_y       = evt.coord_y;
    assign ev.length        = evt.length;
    assign ev.bus_error     = evt.bus_error;
    assign ev.ack_value     = evt.ack_value;
    assign ev.issue_refused = evt.issue_refused;

    cts_step u_step
    (
        .cur (state_reg),
        .cfg (cfg),
        .ev  (ev),
        .nxt (state_next),
        .res (step_res)
    );

    assign evt.ready = !res_valid_reg || res.ready;
    assign accept    = evt.valid && evt.ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (accept)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase             <= cts_pkg::PH_IDLE;
            state_reg.job_kind          <= cts_pkg::KIND_NONE;
            state_reg.retries_remaining <= '0;
            state_reg.elapsed_ticks     <= '0;
            state_reg.ready_latched     <= 1'b0;
            state_reg.final_result      <= cts_pkg::RES_NO_JOB;
            state_reg.job_x             <= '0;
            state_reg.job_y             <= '0;
            state_reg.job_length        <= '0;
            res_valid_reg               <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= step_res;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.start_status = res_reg.start_status;
    assign res.action       = res_reg.action;
    assign res.out_x        = res_reg.out_x;
    assign res.out_y        = res_reg.out_y;
    assign res.out_length   = res_reg.out_length;
    assign res.job_status   = res_reg.job_status;

    a_cmd_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_reg.action == cts_pkg::ACT_WRITE
                          || res_reg.action == cts_pkg::ACT_READ)
        |-> state_reg.phase == cts_pkg::PH_SENDING)
        else $error("command sent but not in sending phase");

    a_readback_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.action == cts_pkg::ACT_READBACK
        |-> state_reg.phase == cts_pkg::PH_READING)
        else $error("readback issued but not in reading phase");

    a_abort_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.action == cts_pkg::ACT_ABORT
        |-> state_reg.phase == cts_pkg::PH_DONE
            && state_reg.final_result == cts_pkg::RES_TIMEOUT)
        else $error("abort without timeout result");

    a_pending_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.job_status == cts_pkg::RES_PENDING
        |-> state_reg.phase != cts_pkg::PH_IDLE && state_reg.phase != cts_pkg::PH_DONE)
        else $error("pending status while no job runs");

endmodule
